### sv/twm_pkg.sv
// Shared types and constants of the timing wheel timer manager.
// Used by twm_mod and timing_wheel_timer_manager_top; depends on nothing.
package twm_pkg;

  localparam int unsigned WheelSlotsDef  = 64;
  localparam int unsigned PoolEntriesDef = 64;
  localparam int unsigned IntervalW      = 16;
  localparam int unsigned DigitW         = 4;
  localparam int unsigned PayloadW       = 20;
  localparam int unsigned SlotOutW       = 6;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ADD_OK   = 3'd0,
    KIND_ADD_FULL = 3'd1,
    KIND_EXPIRED  = 3'd2,
    KIND_NONE     = 3'd3,
    KIND_CLEARED  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_ADD_RD,
    S_ADD_WR,
    S_ADD_LINK,
    S_TICK_HD,
    S_TICK_WALK
  } state_e;

endpackage

### sv/timing_wheel_timer_manager_top.sv
// Top level of the single-level hashed timing wheel timer manager.
// Depends on twm_pkg and twm_mod.

// A request is taken when start_i is high and busy_o is low; every result it
// causes appears on the result ports for exactly one cycle with valid_o high,
// and the receiver cannot stall them, so it must take a result in every cycle
// that valid_o is high. An add, once taken, reduces the interval modulo the slot
// count (four steps of one hex digit each, then the remainder is handed over),
// then reads the slot and entry memories and, unless the pool is full, writes
// them, with a link write when the slot was not empty. A tick reads the head of
// the next slot, then the expiry walk follows the slot's linked list one
// entry-memory read per cycle. A clear, and likewise the start-up after reset,
// sweeps the slot, link and free-list memories one address per cycle; busy_o
// stays high during the sweep.
// An unknown command is taken and ignored without any result.
module timing_wheel_timer_manager_top #(
  parameter int unsigned WHEEL_SLOTS  = twm_pkg::WheelSlotsDef,
  parameter int unsigned POOL_ENTRIES = twm_pkg::PoolEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] interval_i,
  input  logic [7:0]  peer_address_i,
  input  logic [7:0]  frame_type_i,
  input  logic [3:0]  handler_tag_i,
  output logic        valid_o,
  output logic [2:0]  kind_o,
  output logic [7:0]  peer_address_res_o,
  output logic [7:0]  frame_kind_o,
  output logic [3:0]  action_tag_o,
  output logic [5:0]  slot_index_o,
  output logic        last_o
);
  import twm_pkg::*;

  localparam int unsigned SW    = $clog2(WHEEL_SLOTS);
  localparam int unsigned EW    = $clog2(POOL_ENTRIES);
  localparam int unsigned CW    = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned NPass = (WHEEL_SLOTS > POOL_ENTRIES) ? WHEEL_SLOTS : POOL_ENTRIES;
  localparam int unsigned PW    = $clog2(NPass);
  localparam int unsigned SdW   = 1 + 2 * EW;
  localparam int unsigned NxW   = 1 + EW;
  localparam logic [SW:0]   WSum     = (SW+1)'(WHEEL_SLOTS);
  localparam logic [SW-1:0] WLast    = SW'(WHEEL_SLOTS - 1);
  localparam logic [CW-1:0] PoolFull = CW'(POOL_ENTRIES);
  localparam logic [PW-1:0] PassLast = PW'(NPass - 1);

  // Control and payload registers.
  state_e              state_q, state_d;
  logic [SW-1:0]       cur_q, cur_d, cur_inc;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [EW-1:0]       e_q, e_d;
  logic [EW-1:0]       tail_q, tail_d;
  logic [CW-1:0]       n_q, n_d;
  logic [PW-1:0]       pass_q, pass_d;
  logic                clr_q, clr_d;
  logic [PayloadW-1:0] pay_q, pay_d;

  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q, out_kind_d;
  logic [PayloadW-1:0] out_pay_q, out_pay_d;
  logic [SW-1:0]       out_slot_q, out_slot_d;
  logic                out_last_q, out_last_d;

  logic                mod_start, mod_done;
  logic [SW-1:0]       mod_rem;
  logic [SW:0]         slot_sum;
  logic                more;

  // Memories. A slot word holds {valid, head, tail}; a link word holds {valid, next}.
  logic [SdW-1:0]      slot_mem [WHEEL_SLOTS];
  logic [PayloadW-1:0] pay_mem  [POOL_ENTRIES];
  logic [NxW-1:0]      next_mem [POOL_ENTRIES];
  logic [EW-1:0]       free_mem [POOL_ENTRIES];

  logic                slot_we;
  logic [SW-1:0]       slot_waddr, slot_raddr;
  logic [SdW-1:0]      slot_wdata, slot_rdata;
  logic                pay_we;
  logic [EW-1:0]       pay_waddr, ent_raddr;
  logic [PayloadW-1:0] pay_rdata;
  logic                next_we;
  logic [EW-1:0]       next_waddr;
  logic [NxW-1:0]      next_wdata, next_rdata;
  logic                free_we;
  logic [EW-1:0]       free_waddr, free_wdata, free_raddr, free_rdata;

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_q;
    end
    pay_rdata <= pay_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rdata <= next_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    free_rdata <= free_mem[free_raddr];
  end

  twm_mod #(
    .WHEEL_SLOTS(WHEEL_SLOTS)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .interval_i(interval_i),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign cur_inc    = (cur_q == WLast) ? '0 : cur_q + 1'b1;
  assign free_raddr = EW'(cnt_q - 1'b1);
  assign more       = next_rdata[NxW-1] && (({1'b0, n_q} + 1'b1) < (CW+1)'(POOL_ENTRIES));

  always_comb begin
    slot_sum = {1'b0, cur_q} + {1'b0, mod_rem};
    if (slot_sum >= WSum) begin
      slot_sum = slot_sum - WSum;
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    e_d         = e_q;
    tail_d      = tail_q;
    n_d         = n_q;
    pass_d      = pass_q;
    clr_d       = clr_q;
    pay_d       = pay_q;
    out_valid_d = 1'b0;
    out_kind_d  = out_kind_q;
    out_pay_d   = '0;
    out_slot_d  = out_slot_q;
    out_last_d  = 1'b1;
    mod_start   = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = slot_q;
    slot_wdata  = '0;
    slot_raddr  = slot_q;
    pay_we      = 1'b0;
    pay_waddr   = free_rdata;
    ent_raddr   = e_q;
    next_we     = 1'b0;
    next_waddr  = e_q;
    next_wdata  = '0;
    free_we     = 1'b0;
    free_waddr  = EW'(cnt_q);
    free_wdata  = e_q;

    case (state_q)
      S_INIT: begin
        // Sweep: empty every slot, drop every link, restack the whole pool.
        slot_waddr = SW'(pass_q);
        slot_we    = (32'(pass_q) < WHEEL_SLOTS);
        next_waddr = EW'(pass_q);
        next_we    = (32'(pass_q) < POOL_ENTRIES);
        free_waddr = EW'(pass_q);
        free_wdata = EW'(pass_q);
        free_we    = next_we;
        pass_d     = pass_q + 1'b1;
        if (pass_q == PassLast) begin
          cnt_d   = PoolFull;
          pass_d  = '0;
          state_d = S_IDLE;
          if (clr_q) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_CLEARED;
            out_slot_d  = cur_q;
          end
        end
      end
      S_IDLE: begin
        slot_raddr = cur_inc;
        if (start_i) begin
          case (command_i)
            CMD_ADD: begin
              mod_start = 1'b1;
              pay_d     = {handler_tag_i, frame_type_i, peer_address_i};
              state_d   = S_MOD;
            end
            CMD_TICK: begin
              cur_d   = cur_inc;
              state_d = S_TICK_HD;
            end
            CMD_CLEAR: begin
              clr_d   = 1'b1;
              pass_d  = '0;
              state_d = S_INIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          slot_d  = slot_sum[SW-1:0];
          state_d = S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        if (cnt_q == '0) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_ADD_FULL;
          out_slot_d  = slot_q;
          state_d     = S_IDLE;
        end else begin
          state_d = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        // The popped entry already has its link cleared from when it was freed.
        pay_we      = 1'b1;
        cnt_d       = cnt_q - 1'b1;
        slot_we     = 1'b1;
        e_d         = free_rdata;
        tail_d      = slot_rdata[EW-1:0];
        out_valid_d = 1'b1;
        out_kind_d  = KIND_ADD_OK;
        out_slot_d  = slot_q;
        if (slot_rdata[SdW-1]) begin
          slot_wdata = {1'b1, slot_rdata[2*EW-1:EW], free_rdata};
          state_d    = S_ADD_LINK;
        end else begin
          slot_wdata = {1'b1, free_rdata, free_rdata};
          state_d    = S_IDLE;
        end
      end
      S_ADD_LINK: begin
        next_we    = 1'b1;
        next_waddr = tail_q;
        next_wdata = {1'b1, e_q};
        state_d    = S_IDLE;
      end
      S_TICK_HD: begin
        slot_waddr = cur_q;
        if (slot_rdata[SdW-1]) begin
          slot_we   = 1'b1;
          ent_raddr = slot_rdata[2*EW-1:EW];
          e_d       = slot_rdata[2*EW-1:EW];
          n_d       = '0;
          state_d   = S_TICK_WALK;
        end else begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_NONE;
          out_slot_d  = cur_q;
          state_d     = S_IDLE;
        end
      end
      S_TICK_WALK: begin
        out_valid_d = 1'b1;
        out_kind_d  = KIND_EXPIRED;
        out_pay_d   = pay_rdata;
        out_slot_d  = cur_q;
        out_last_d  = !more;
        next_we     = 1'b1;
        if (cnt_q < PoolFull) begin
          free_we = 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end
        if (more) begin
          ent_raddr = next_rdata[EW-1:0];
          e_d       = next_rdata[EW-1:0];
          n_d       = n_q + 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_q       <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      pass_q      <= '0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      pass_q      <= pass_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    e_q        <= e_d;
    tail_q     <= tail_d;
    pay_q      <= pay_d;
    out_kind_q <= out_kind_d;
    out_pay_q  <= out_pay_d;
    out_slot_q <= out_slot_d;
    out_last_q <= out_last_d;
  end

  assign busy_o             = (state_q != S_IDLE);
  assign valid_o            = out_valid_q;
  assign kind_o             = out_kind_q;
  assign peer_address_res_o = out_pay_q[7:0];
  assign frame_kind_o       = out_pay_q[15:8];
  assign action_tag_o       = out_pay_q[19:16];
  assign slot_index_o       = SlotOutW'(out_slot_q);
  assign last_o             = out_last_q;

`ifndef SYNTH
  // The free count can never exceed the pool size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PoolFull)
    else $error("free count above pool size");

  // Only an expiry walk produces results that are not the last of their request.
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> kind_o == KIND_EXPIRED)
    else $error("non-final result that is not an expiry");

  // An accepted tick advances the current slot by exactly one, modulo the wheel size.
  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && command_i == CMD_TICK |=>
      cur_q == (($past(cur_q) == WLast) ? '0 : $past(cur_q) + 1'b1))
    else $error("tick did not advance the wheel by one slot");

  // An expiry walk never emits more results than the pool has entries.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TICK_WALK |-> n_q < PoolFull)
    else $error("expiry walk longer than the pool");
`endif

endmodule

### sv/twm_mod.sv
// Reduces a 16-bit interval modulo the wheel slot count, one hex digit per cycle.
// Depends on twm_pkg.
module twm_mod #(
  parameter int unsigned WHEEL_SLOTS = twm_pkg::WheelSlotsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [twm_pkg::IntervalW-1:0]      interval_i,
  output logic                               done_o,
  output logic [$clog2(WHEEL_SLOTS)-1:0]     rem_o
);
  import twm_pkg::*;

  localparam int unsigned SW    = $clog2(WHEEL_SLOTS);
  localparam int unsigned Steps = IntervalW / DigitW;
  localparam int unsigned StW   = (Steps > 1) ? $clog2(Steps) : 1;
  localparam logic [SW:0] WMod  = (SW+1)'(WHEEL_SLOTS);
  localparam logic [StW-1:0] LastStep = StW'(Steps - 1);

  logic [IntervalW-1:0] sh_q, sh_d;
  logic [SW-1:0]        r_q, r_d, r_n;
  logic [StW-1:0]       cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [SW:0]          t;

  // Each step shifts in one hex digit, one interval bit at a time, each bit followed by one conditional subtract.
  always_comb begin
    r_n = r_q;
    t   = '0;
    for (int k = 0; k < DigitW; k++) begin
      t = {r_n, sh_q[IntervalW-1-k]};
      if (t >= WMod) begin
        t = t - WMod;
      end
      r_n = t[SW-1:0];
    end
  end

  always_comb begin
    sh_d   = sh_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d  = interval_i;
      r_d   = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      sh_d  = sh_q << DigitW;
      r_d   = r_n;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q  <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

### dv/tb_timing_wheel_timer_manager_top.sv
// Self-checking testbench of the timing wheel timer manager top level.
// Depends on twm_pkg and timing_wheel_timer_manager_top; the wheel is modeled
// inside the bench and every result is compared with the modeled one.
module tb_timing_wheel_timer_manager_top;
  import twm_pkg::*;

  localparam int Slots = 64;
  localparam int Pool  = 64;
  localparam int CycleLimit = 400000;

  // One expected (or observed) result.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] peer;
    logic [7:0] frame;
    logic [3:0] tag;
    logic [5:0] slot;
    logic       last;
  } timer_result_t;

  // One row of the directed table. When check_it is set the first result that
  // the request causes is also compared with the typed-in value.
  typedef struct {
    logic [1:0]    cmd;
    logic [15:0]   ivl;
    logic [7:0]    peer;
    logic [7:0]    frame;
    logic [3:0]    tag;
    bit            check_it;
    timer_result_t want;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  command_i;
  logic [15:0] interval_i;
  logic [7:0]  peer_address_i;
  logic [7:0]  frame_type_i;
  logic [3:0]  handler_tag_i;
  logic        valid_o;
  logic [2:0]  kind_o;
  logic [7:0]  peer_address_res_o;
  logic [7:0]  frame_kind_o;
  logic [3:0]  action_tag_o;
  logic [5:0]  slot_index_o;
  logic        last_o;

  timing_wheel_timer_manager_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .command_i          (command_i),
    .interval_i         (interval_i),
    .peer_address_i     (peer_address_i),
    .frame_type_i       (frame_type_i),
    .handler_tag_i      (handler_tag_i),
    .valid_o            (valid_o),
    .kind_o             (kind_o),
    .peer_address_res_o (peer_address_res_o),
    .frame_kind_o       (frame_kind_o),
    .action_tag_o       (action_tag_o),
    .slot_index_o       (slot_index_o),
    .last_o             (last_o)
  );

  // Shadow copy of the wheel. Each slot keeps its timers as a FIFO of packed
  // payloads; the pool is tracked as a free-entry count only.
  logic [19:0]   wheel_fifo [Slots][$];
  int unsigned   wheel_now;
  int unsigned   pool_free;
  timer_result_t pending_results [$];
  int unsigned   first_new_idx;
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   sender_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic timer_result_t make_result(kind_e k, logic [19:0] pl, int unsigned s,
                                                logic lst);
    timer_result_t r;
    r.kind  = k;
    r.peer  = pl[7:0];
    r.frame = pl[15:8];
    r.tag   = pl[19:16];
    r.slot  = s[5:0];
    r.last  = lst;
    return r;
  endfunction

  // Applies one request to the shadow wheel and queues the results it causes.
  // The queue position of its first result is kept for the directed checks.
  function automatic void predict_wheel(logic [1:0] cmd, logic [15:0] ivl, logic [7:0] peer,
                                        logic [7:0] frame, logic [3:0] tag);
    int unsigned s;
    int unsigned n;
    first_new_idx = pending_results.size();
    case (cmd)
      CMD_ADD: begin
        s = (wheel_now + ivl) % Slots;
        if (pool_free == 0) begin
          pending_results.push_back(make_result(KIND_ADD_FULL, '0, s, 1'b1));
        end else begin
          pool_free--;
          wheel_fifo[s].push_back({tag, frame, peer});
          pending_results.push_back(make_result(KIND_ADD_OK, '0, s, 1'b1));
        end
      end
      CMD_TICK: begin
        wheel_now = (wheel_now + 1) % Slots;
        n = wheel_fifo[wheel_now].size();
        if (n == 0) begin
          pending_results.push_back(make_result(KIND_NONE, '0, wheel_now, 1'b1));
        end
        for (int i = 0; i < n; i++) begin
          pending_results.push_back(make_result(KIND_EXPIRED, wheel_fifo[wheel_now][i],
                                                wheel_now, i == n - 1));
        end
        wheel_fifo[wheel_now].delete();
        pool_free += n;
      end
      CMD_CLEAR: begin
        foreach (wheel_fifo[i]) wheel_fifo[i].delete();
        pool_free = Pool;
        pending_results.push_back(make_result(KIND_CLEARED, '0, wheel_now, 1'b1));
      end
      default: begin
        // The unknown command is swallowed without any result.
      end
    endcase
  endfunction

  // Drives one request and holds it until the block takes it. The start is
  // held high across back-to-back requests, so it is only lowered on idling and while draining.
  task automatic send_request(logic [1:0] cmd, logic [15:0] ivl, logic [7:0] peer,
                              logic [7:0] frame, logic [3:0] tag);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    command_i      <= cmd;
    interval_i     <= ivl;
    peer_address_i <= peer;
    frame_type_i   <= frame;
    handler_tag_i  <= tag;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_wheel(cmd, ivl, peer, frame, tag);
  endtask

  task automatic drop_start();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected result has come, then lets the block settle;
  // an unknown command leaves no result behind to wait for.
  task automatic wait_drained();
    drop_start();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Results are sampled at the rising edge; the block cannot be stalled.
  always @(posedge clk_i) begin
    timer_result_t got;
    timer_result_t want;
    if (rst_ni && valid_o) begin
      got = '{kind_o, peer_address_res_o, frame_kind_o, action_tag_o, slot_index_o, last_o};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result %p", got);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  directed_row_t directed_rows [] = '{
    // A tick on the empty wheel lands on slot 1 and finds nothing.
    '{CMD_TICK,  16'd0,     8'h00, 8'h00, 4'h0, 1'b1, '{KIND_NONE, 0, 0, 0, 6'd1, 1'b1}},
    // Add with the largest interval: (1 + 65535) mod 64 is slot 0.
    '{CMD_ADD,   16'hFFFF,  8'hFF, 8'hFF, 4'hF, 1'b1, '{KIND_ADD_OK, 0, 0, 0, 6'd0, 1'b1}},
    // Interval zero only fires after a whole turn of the wheel.
    '{CMD_ADD,   16'd0,     8'h00, 8'h00, 4'h0, 1'b1, '{KIND_ADD_OK, 0, 0, 0, 6'd1, 1'b1}},
    '{CMD_ADD,   16'd1,     8'hA5, 8'h5A, 4'h9, 1'b1, '{KIND_ADD_OK, 0, 0, 0, 6'd2, 1'b1}},
    '{CMD_ADD,   16'd65,    8'h3C, 8'hC3, 4'h6, 1'b0, '0},
    '{CMD_ADD,   16'd1,     8'h01, 8'h80, 4'h1, 1'b0, '0},
    // Three timers fire from slot 2 in the order they were filed.
    '{CMD_TICK,  16'hAAAA,  8'h55, 8'hAA, 4'h5, 1'b0, '0},
    '{CMD_ADD,   16'd63,    8'h12, 8'h34, 4'h8, 1'b0, '0},
    // An unknown command is ignored and produces nothing.
    '{2'd3,      16'h5555,  8'hAA, 8'h55, 4'hA, 1'b0, '0},
    '{CMD_TICK,  16'd0,     8'h00, 8'h00, 4'h0, 1'b0, '0},
    // Clear keeps the current slot, which is 3 now.
    '{CMD_CLEAR, 16'd7,     8'h77, 8'h77, 4'h7, 1'b1, '{KIND_CLEARED, 0, 0, 0, 6'd3, 1'b1}},
    '{CMD_TICK,  16'd0,     8'h00, 8'h00, 4'h0, 1'b1, '{KIND_NONE, 0, 0, 0, 6'd4, 1'b1}}
  };

  initial begin
    logic [1:0]  cmd;
    logic [15:0] ivl;
    int unsigned pick;

    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    command_i      <= CMD_ADD;
    interval_i     <= '0;
    peer_address_i <= '0;
    frame_type_i   <= '0;
    handler_tag_i  <= '0;
    wheel_now       = 0;
    pool_free       = Pool;
    first_new_idx   = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sender_idle_pct = 29;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; typed-in results must agree with the shadow wheel too.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].ivl, directed_rows[i].peer,
                   directed_rows[i].frame, directed_rows[i].tag);
      if (directed_rows[i].check_it &&
          (pending_results.size() <= first_new_idx ||
           pending_results[first_new_idx] !== directed_rows[i].want)) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("table row %0d: expected %p", i, directed_rows[i].want);
        end
      end
    end
    wait_drained();

    // Fill the pool completely into one slot, overflow it, then expire the
    // whole slot in a single tick: the longest walk and the pool-full reject.
    for (int i = 0; i < Pool + 2; i++) begin
      send_request(CMD_ADD, 16'd1 + 16'(Slots * $urandom_range(3, 0)),
                   8'($urandom), 8'($urandom), 4'($urandom));
    end
    send_request(CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
    wait_drained();

    // Random phases: sender idling, then a quieter sender, then none.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 81 : 0;
      for (int i = 0; i < 11; i++) begin
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
          cmd = CMD_ADD;
        end else if (pick < 93) begin
          cmd = CMD_TICK;
        end else if (pick < 97) begin
          cmd = CMD_CLEAR;
        end else begin
          cmd = 2'd3;
        end
        // Mostly short intervals so timers come due soon; some full range.
        ivl = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(4, 0));
        send_request(cmd, ivl, 8'($urandom), 8'($urandom), 4'($urandom));
      end
      // The sender holds off here until every outstanding result is back.
      wait_drained();
    end

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
